>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante implies cons in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication failed");

// expr must never hold
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("%m: forbidden condition seen");

`endif

>>> rtl/bpfr_pkg.sv
// ---------------------------------------------------------------------------
// bpfr_pkg
// Types, register indexes and helpers for the byte pattern find/replace core.
// ---------------------------------------------------------------------------
package bpfr_pkg;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;
   localparam int COUNT_W    = 32;
   localparam int REG_BYTES  = 8;

   typedef enum logic [1:0] {
      CSR_PATTERN     = 2'd0,
      CSR_LENGTH      = 2'd1,
      CSR_REPLACEMENT = 2'd2,
      CSR_REPL_EN     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [63:0] pattern;
      logic [3:0]  length;
      logic [63:0] replacement;
      logic        replace_en;
   } cfg_type;

   typedef struct packed {
      logic [7:0]         out_byte;
      logic               out_last;
      logic [COUNT_W-1:0] match_count;
      logic               found;
      logic [31:0]        first_offset;
   } result_entry_type;

   // byte k of a 64-bit register; bytes past the eighth read as zero
   function automatic logic [7:0] reg_byte(input logic [63:0] value, input int k);
      logic [7:0] b;
      b = 8'd0;
      for (int i = 0; i < REG_BYTES; i++) begin
         if (i == k) begin
            b = value[8*i +: 8];
         end
      end
      return b;
   endfunction

endpackage

>>> rtl/bpfr_csr.sv
// ---------------------------------------------------------------------------
// bpfr_csr
// APB-style register file holding pattern, length, replacement and enable.
// ---------------------------------------------------------------------------
module bpfr_csr import bpfr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;
   logic          wr_en;

   assign index      = csr_index_type'(csr_paddr[CSR_ADDR_W-1 -: 2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            CSR_PATTERN:     cfg_in.pattern     = csr_pwdata;
            CSR_LENGTH:      cfg_in.length      = csr_pwdata[3:0];
            CSR_REPLACEMENT: cfg_in.replacement = csr_pwdata;
            CSR_REPL_EN:     cfg_in.replace_en  = csr_pwdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         CSR_PATTERN:     csr_prdata = cfg_ff.pattern;
         CSR_LENGTH:      csr_prdata = {60'd0, cfg_ff.length};
         CSR_REPLACEMENT: csr_prdata = cfg_ff.replacement;
         CSR_REPL_EN:     csr_prdata = {63'd0, cfg_ff.replace_en};
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern     <= 64'd0;
         cfg_ff.length      <= 4'd4;
         cfg_ff.replacement <= 64'd0;
         cfg_ff.replace_en  <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/bpfr_engine.sv
// ---------------------------------------------------------------------------
// bpfr_engine
// Input register, pending byte window, pattern compare and match status.
// Each processed word releases its zero or more result entries all together.
// ---------------------------------------------------------------------------
module bpfr_engine import bpfr_pkg::*; #(
   parameter int MAX_PATTERN = 8,
   parameter int OFFSET_BITS = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [7:0]                             req_data_byte,
   input  logic                                   req_last_byte,
   input  cfg_type                                cfg,
   input  logic                                   room,
   output logic [$clog2(MAX_PATTERN+1)-1:0]       wr_count,
   output result_entry_type                       wr_entries [MAX_PATTERN]
);

   localparam int W = $clog2(MAX_PATTERN + 1);

   logic                   in_valid_ff, in_valid_in;
   logic [7:0]             in_byte_ff;
   logic                   in_last_ff;
   logic [7:0]             win_ff [MAX_PATTERN];
   logic [7:0]             win_in [MAX_PATTERN];
   logic [W-1:0]           fill_ff, fill_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [OFFSET_BITS-1:0] first_ff, first_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic                   found_ff, found_in;

   logic                   fire, take;
   logic [W-1:0]           len, keep, pre, tot, n;
   logic                   full, hit, flush_all;
   logic [7:0]             seq [MAX_PATTERN];
   logic [7:0]             seg [MAX_PATTERN];
   logic [COUNT_W-1:0]     count_new;
   logic                   found_new;
   logic [OFFSET_BITS-1:0] first_new;

   assign fire        = in_valid_ff && room;
   assign req_stall   = in_valid_ff && !room;
   assign take        = req_valid && !req_stall;
   assign in_valid_in = take || (in_valid_ff && !fire);

   // length register clamped to the window size
   assign len  = (5'(cfg.length) > 5'(MAX_PATTERN)) ? W'(MAX_PATTERN) : W'(cfg.length);
   assign keep = (len == '0) ? '0 : len - W'(1);
   // oldest bytes that no longer fit a shortened window leave first
   assign pre  = (fill_ff > keep) ? fill_ff - keep : '0;
   assign tot  = fill_ff + W'(1);
   assign full = (len != '0) && ((tot - pre) == len);

   // pending bytes followed by the new one
   always_comb begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
         seq[j] = (j < int'(fill_ff)) ? win_ff[j] : in_byte_ff;
      end
   end

   // candidate span starts after the bytes pushed out by a shorter window
   always_comb begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
         seg[i] = 8'd0;
         for (int k = 0; k < MAX_PATTERN; k++) begin
            if (int'(pre) + i == k) begin
               seg[i] = seq[k];
            end
         end
      end
   end

   always_comb begin
      hit = full;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if (i < int'(len) && seg[i] != reg_byte(cfg.pattern, i)) begin
            hit = 1'b0;
         end
      end
   end

   assign flush_all = (len == '0) || hit || in_last_ff;

   always_comb begin
      if (flush_all) begin
         n = tot;
      end else if (full) begin
         n = pre + W'(1);
      end else begin
         n = pre;
      end
   end

   assign count_new = (hit && count_ff != '1) ? count_ff + COUNT_W'(1) : count_ff;
   assign found_new = found_ff || hit;
   assign first_new = (hit && !found_ff) ? pos_ff - OFFSET_BITS'(keep) : first_ff;

   always_comb begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
         logic upd;
         upd = hit && (j >= int'(pre));
         if (upd && cfg.replace_en) begin
            wr_entries[j].out_byte = reg_byte(cfg.replacement, j - int'(pre));
         end else begin
            wr_entries[j].out_byte = seq[j];
         end
         wr_entries[j].out_last    = in_last_ff && (j == int'(n) - 1);
         wr_entries[j].match_count = upd ? count_new : count_ff;
         wr_entries[j].found       = upd ? found_new : found_ff;
         if (upd ? found_new : found_ff) begin
            wr_entries[j].first_offset = upd ? 32'(first_new) : 32'(first_ff);
         end else begin
            wr_entries[j].first_offset = 32'd0;
         end
      end
   end

   assign wr_count = fire ? n : '0;

   always_comb begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
         win_in[i] = win_ff[i];
         if (fire) begin
            for (int k = 0; k < MAX_PATTERN; k++) begin
               if (int'(n) + i == k) begin
                  win_in[i] = seq[k];
               end
            end
         end
      end
   end

   always_comb begin
      fill_in  = fill_ff;
      pos_in   = pos_ff;
      count_in = count_ff;
      found_in = found_ff;
      first_in = first_ff;
      if (fire) begin
         if (in_last_ff) begin
            fill_in  = '0;
            pos_in   = '0;
            count_in = '0;
            found_in = 1'b0;
            first_in = '0;
         end else begin
            fill_in  = flush_all ? '0 : tot - n;
            pos_in   = (pos_ff != '1) ? pos_ff + OFFSET_BITS'(1) : pos_ff;
            count_in = count_new;
            found_in = found_new;
            first_in = first_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         fill_ff     <= '0;
         pos_ff      <= '0;
         count_ff    <= '0;
         found_ff    <= 1'b0;
         first_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         fill_ff     <= fill_in;
         pos_ff      <= pos_in;
         count_ff    <= count_in;
         found_ff    <= found_in;
         first_ff    <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
      win_ff <= win_in;
   end

endmodule

>>> rtl/bpfr_result_queue.sv
// ---------------------------------------------------------------------------
// bpfr_result_queue
// Result queue: takes up to MAX_PATTERN words per cycle, gives one per cycle while rsp_stall is low.
// ---------------------------------------------------------------------------
module bpfr_result_queue import bpfr_pkg::*; #(
   parameter int MAX_PATTERN = 8
) (
   input  logic                                                 clock,
   input  logic                                                 reset,
   input  logic [$clog2(MAX_PATTERN+1)-1:0]                     wr_count,
   input  result_entry_type                                     wr_entries [MAX_PATTERN],
   output logic                                                 rsp_valid,
   input  logic                                                 rsp_stall,
   output result_entry_type                                     rsp_entry,
   output logic                                                 room,
   output logic [$clog2(1 << $clog2(2*MAX_PATTERN)):0]          level
);

   localparam int DEPTH = 1 << $clog2(2 * MAX_PATTERN);
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = PTR_W + 1;

   result_entry_type mem_ff [DEPTH];
   result_entry_type wdata  [DEPTH];
   logic             wen    [DEPTH];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] level_ff, level_in;
   logic [PTR_W-1:0] tail;
   logic             pop;

   assign tail      = head_ff + level_ff[PTR_W-1:0];
   assign rsp_valid = (level_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_entry = mem_ff[head_ff];
   assign level     = level_ff;
   // a processed word may release up to MAX_PATTERN entries
   assign room      = (level_ff <= CNT_W'(DEPTH - MAX_PATTERN));

   always_comb begin
      for (int e = 0; e < DEPTH; e++) begin
         logic [PTR_W-1:0] off;
         off      = PTR_W'(e) - tail;
         wen[e]   = (int'(off) < int'(wr_count));
         wdata[e] = wr_entries[0];
         for (int k = 0; k < MAX_PATTERN; k++) begin
            if (k == int'(off)) begin
               wdata[e] = wr_entries[k];
            end
         end
      end
   end

   assign head_in  = pop ? head_ff + PTR_W'(1) : head_ff;
   assign level_in = level_ff + CNT_W'(wr_count) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         level_ff <= '0;
      end else begin
         head_ff  <= head_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int e = 0; e < DEPTH; e++) begin
         if (wen[e]) begin
            mem_ff[e] <= wdata[e];
         end
      end
   end

endmodule

>>> rtl/byte_pattern_find_replace_core.sv
// ---------------------------------------------------------------------------
// byte_pattern_find_replace_core
// Streaming search of a byte buffer for a 1..MAX_PATTERN byte pattern, with
// optional in-place replacement and match statistics.
// ---------------------------------------------------------------------------
// Bytes enter one per cycle and leave in the same order, one per cycle, when
// not stalled, with non-overlapping matches (left to right) overwritten by the
// replacement when replace_en is set. A byte is registered on entry and decided
// once the result queue has room; with a pattern of L bytes up to L-1 bytes are
// held back until the compare settles, so a byte reaches the output once L-1
// later bytes have arrived, or at once on the last byte. A match releases all L
// bytes together into a result queue of 2*MAX_PATTERN words (rounded up to a
// power of two) that drains one word per cycle while rsp_stall is low; req_stall
// rises only while a byte waits and the queue holds more than Q_DEPTH minus
// MAX_PATTERN words, so sustained throughput is one byte per cycle whenever the
// result side keeps up. Registers sit at byte addresses 0x00 pattern, 0x08
// length, 0x10 replacement, 0x18 enable; change them only between buffers.
`include "assert_macros.svh"

module byte_pattern_find_replace_core import bpfr_pkg::*; #(
   parameter int MAX_PATTERN = 8,
   parameter int OFFSET_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_last_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_out_last,
   output logic [COUNT_W-1:0]    rsp_match_count,
   output logic                  rsp_found,
   output logic [31:0]           rsp_first_offset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int W       = $clog2(MAX_PATTERN + 1);
   localparam int Q_DEPTH = 1 << $clog2(2 * MAX_PATTERN);
   localparam int Q_CNT_W = $clog2(Q_DEPTH) + 1;

   cfg_type          cfg;
   logic             room;
   logic [W-1:0]     wr_count;
   result_entry_type wr_entries [MAX_PATTERN];
   result_entry_type rsp_entry;
   logic [Q_CNT_W-1:0] q_level;

   bpfr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bpfr_engine #(
      .MAX_PATTERN (MAX_PATTERN),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .cfg           (cfg),
      .room          (room),
      .wr_count      (wr_count),
      .wr_entries    (wr_entries)
   );

   bpfr_result_queue #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .wr_count   (wr_count),
      .wr_entries (wr_entries),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_entry  (rsp_entry),
      .room       (room),
      .level      (q_level)
   );

   assign rsp_out_byte     = rsp_entry.out_byte;
   assign rsp_out_last     = rsp_entry.out_last;
   assign rsp_match_count  = rsp_entry.match_count;
   assign rsp_found        = rsp_entry.found;
   assign rsp_first_offset = rsp_entry.first_offset;

   // out of reset nothing is pending and the input side is open
   `ASSERT_IMPLIES(a_reset_clean, clock, reset, $past(reset), !rsp_valid && !req_stall)
   // no match seen means no count and no offset
   `ASSERT_IMPLIES(a_count_needs_found, clock, reset, rsp_valid && !rsp_found,
                   rsp_match_count == '0 && rsp_first_offset == 32'd0)
   // a found flag always comes with at least one counted match
   `ASSERT_IMPLIES(a_found_has_count, clock, reset, rsp_valid && rsp_found,
                   rsp_match_count != '0)
   // the queue must never be over-filled
   `ASSERT_NEVER(a_queue_bound, clock, reset, q_level > Q_CNT_W'(Q_DEPTH))

endmodule

>>> test/byte_pattern_find_replace_core_test.sv
// ---------------------------------------------------------------------------
// byte_pattern_find_replace_core_test
// Self-checking bench for the streaming pattern find/replace core. A short
// table of directed words and register writes is followed by random buffers
// over several register settings. Every accepted input word goes through a local
// model of the search window; each result word is checked field by field, in
// order, against that model or, for typed table rows, the word the table gives.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module byte_pattern_find_replace_core_test;
   import bpfr_pkg::*;

   localparam int HALF_PERIOD    = 1;
   localparam int RESET_CYCLES   = 6;
   localparam int RANDOM_WORDS   = 90;
   localparam int SETTLE_CYCLES  = 8;
   localparam int DRAIN_CYCLES   = 20;
   localparam int HOLD_CYCLES    = 80;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int WIN_DEPTH      = 8;
   localparam int REPORT_LIMIT   = 40;

   typedef enum logic {ROW_WRITE, ROW_BYTE} row_kind_type;

   typedef struct {
      row_kind_type     kind;
      csr_index_type    index;
      logic [63:0]      value;
      logic [7:0]       data;
      logic             last;
      logic             typed;
      result_entry_type want;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   wire                   req_stall;
   logic [7:0]            req_data_byte = 8'd0;
   logic                  req_last_byte = 1'b0;
   wire                   rsp_valid;
   logic                  rsp_stall = 1'b0;
   wire [7:0]             rsp_out_byte;
   wire                   rsp_out_last;
   wire [COUNT_W-1:0]     rsp_match_count;
   wire                   rsp_found;
   wire [31:0]            rsp_first_offset;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   wire [CSR_DATA_W-1:0]  csr_prdata;
   wire                   csr_pready;

   byte_pattern_find_replace_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_out_last     (rsp_out_last),
      .rsp_match_count  (rsp_match_count),
      .rsp_found        (rsp_found),
      .rsp_first_offset (rsp_first_offset),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #HALF_PERIOD clock = ~clock;

   // search model: register copy and per-buffer state
   cfg_type          cfg_now;
   logic [7:0]       win [WIN_DEPTH];
   int unsigned      win_fill;
   logic [31:0]      byte_pos;
   logic [31:0]      hits_so_far;
   logic [31:0]      first_hit_at;
   logic             any_hit;
   result_entry_type step_words[$];
   result_entry_type awaited_words[$];

   stim_row_type     directed_rows[$];
   logic             cur_typed = 1'b0;
   result_entry_type cur_want = '0;
   logic             steady_send = 1'b0;
   logic             pressure_phase = 1'b0;
   logic             narrow_alphabet = 1'b0;
   logic             hold_request = 1'b0;
   int               hold_left = 0;
   int               stall_left = 0;
   int               steady_left = 0;

   int error_count = 0;
   int words_in = 0;
   int words_out = 0;
   int hit_total = 0;
   int items_sent = 0;
   int buffers_sent = 0;
   int settings_written = 0;
   int holds_done = 0;
   int idle_cycles = 0;

   function automatic int unsigned gap_length();
      if ($urandom_range(0, 99) < 80) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   function automatic void clear_buffer_state();
      for (int i = 0; i < WIN_DEPTH; i++) begin
         win[i] = 8'd0;
      end
      win_fill     = 0;
      byte_pos     = '0;
      hits_so_far  = '0;
      first_hit_at = '0;
      any_hit      = 1'b0;
   endfunction

   function automatic void release_oldest();
      result_entry_type r;
      r.out_byte = win[0];
      for (int i = 0; i < WIN_DEPTH - 1; i++) begin
         win[i] = win[i + 1];
      end
      win_fill--;
      r.out_last     = 1'b0;
      r.match_count  = hits_so_far;
      r.found        = any_hit;
      r.first_offset = any_hit ? first_hit_at : 32'd0;
      step_words.push_back(r);
   endfunction

   // one byte into the search window; the words it releases go to step_words
   function automatic void find_replace_step(input logic [7:0] b, input logic last);
      int unsigned      len;
      int unsigned      keep;
      logic [31:0]      pos;
      logic             hit;
      result_entry_type tail;
      step_words.delete();
      len = cfg_now.length;
      if (len > WIN_DEPTH) begin
         len = WIN_DEPTH;
      end
      keep = (len == 0) ? 0 : len - 1;
      // a shortened pattern pushes the oldest bytes out untouched
      while (win_fill > keep) begin
         release_oldest();
      end
      win[win_fill] = b;
      win_fill++;
      pos = byte_pos;
      if (byte_pos != 32'hFFFF_FFFF) begin
         byte_pos++;
      end
      if (len == 0) begin
         release_oldest();
      end else if (win_fill == len) begin
         hit = 1'b1;
         for (int i = 0; i < len; i++) begin
            if (win[i] != cfg_now.pattern[8*i +: 8]) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            hit_total++;
            if (hits_so_far != 32'hFFFF_FFFF) begin
               hits_so_far++;
            end
            if (!any_hit) begin
               first_hit_at = pos - (len - 1);
               any_hit      = 1'b1;
            end
            if (cfg_now.replace_en) begin
               for (int i = 0; i < len; i++) begin
                  win[i] = cfg_now.replacement[8*i +: 8];
               end
            end
            // no overlap: the whole match leaves and the search restarts
            while (win_fill > 0) begin
               release_oldest();
            end
         end else begin
            release_oldest();
         end
      end
      if (last) begin
         while (win_fill > 0) begin
            release_oldest();
         end
         if (step_words.size() > 0) begin
            tail = step_words.pop_back();
            tail.out_last = 1'b1;
            step_words.push_back(tail);
         end
         clear_buffer_state();
      end
   endfunction

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         error_count++;
         if (error_count <= REPORT_LIMIT) begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         end
      end
   endtask

   // both channels are sampled here, at the rising edge
   always @(posedge clock) begin
      result_entry_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            words_in++;
            find_replace_step(req_data_byte, req_last_byte);
            if (cur_typed) begin
               awaited_words.push_back(cur_want);
            end else begin
               foreach (step_words[k]) begin
                  awaited_words.push_back(step_words[k]);
               end
            end
         end
         if (rsp_valid && !rsp_stall) begin
            words_out++;
            if (awaited_words.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT) begin
                  $display("%0t ns: result word %0h with nothing awaited", $time, rsp_out_byte);
               end
            end else begin
               want = awaited_words.pop_front();
               compare_field("out_byte", want.out_byte, rsp_out_byte);
               compare_field("out_last", want.out_last, rsp_out_last);
               compare_field("match_count", want.match_count, rsp_match_count);
               compare_field("found", want.found, rsp_found);
               compare_field("first_offset", want.first_offset, rsp_first_offset);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no progress for %0d cycles, %0d words still awaited",
                     idle_cycles, awaited_words.size());
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // result side stalls: short bursts, odd long ones, quiet stretches and
   // one long hold-off on request so the core backs up into its input
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES - 1;
         holds_done++;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         if (steady_left > 0) begin
            steady_left--;
         end else if ($urandom_range(0, 15) == 0) begin
            steady_left = $urandom_range(20, 60);
         end else if ($urandom_range(0, 9) < 4) begin
            stall_left = gap_length();
         end
      end
   end

   task automatic send_byte(input logic [7:0] d, input logic l, input logic typed,
                            input result_entry_type want);
      int unsigned gap;
      gap = (steady_send || $urandom_range(0, 9) < 6) ? 0 : gap_length();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_data_byte <= d;
      req_last_byte <= l;
      cur_typed = typed;
      cur_want  = want;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // quiet the input, wait for every awaited word, then let the pipe empty
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [63:0] value);
      settle();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         CSR_PATTERN:     cfg_now.pattern     = value;
         CSR_LENGTH:      cfg_now.length      = value[3:0];
         CSR_REPLACEMENT: cfg_now.replacement = value;
         CSR_REPL_EN:     cfg_now.replace_en  = value[0];
         default:         ;
      endcase
      settings_written++;
   endtask

   function automatic logic [7:0] noise_byte();
      if (narrow_alphabet) begin
         return 8'h41 + 8'($urandom_range(0, 1));
      end
      return 8'($urandom_range(0, 255));
   endfunction

   // one buffer: whole pattern copies, broken copies and noise, last on the end
   task automatic send_buffer();
      logic [7:0]  bytes_q[$];
      int unsigned n;
      int unsigned len;
      int unsigned cut;
      int unsigned r;
      n   = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
      len = (cfg_now.length > WIN_DEPTH) ? WIN_DEPTH : cfg_now.length;
      steady_send = pressure_phase || ($urandom_range(0, 3) == 0);
      while (bytes_q.size() < n) begin
         r = $urandom_range(0, 3);
         if (len > 0 && r < 2) begin
            cut = len;
         end else if (len > 1 && r == 2) begin
            cut = $urandom_range(1, len - 1);
         end else begin
            cut = 0;
         end
         if (cut == 0) begin
            bytes_q.push_back(noise_byte());
         end else begin
            for (int i = 0; i < cut; i++) begin
               bytes_q.push_back(cfg_now.pattern[8*i +: 8]);
            end
         end
      end
      while (bytes_q.size() > n) begin
         void'(bytes_q.pop_back());
      end
      foreach (bytes_q[k]) begin
         send_byte(bytes_q[k], k == bytes_q.size() - 1, 1'b0, '0);
      end
      buffers_sent++;
   endtask

   function automatic stim_row_type reg_row(input csr_index_type idx, input logic [63:0] v);
      stim_row_type r;
      r.kind  = ROW_WRITE;
      r.index = idx;
      r.value = v;
      r.data  = 8'd0;
      r.last  = 1'b0;
      r.typed = 1'b0;
      r.want  = '0;
      return r;
   endfunction

   function automatic stim_row_type byte_row(input logic [7:0] d, input logic l);
      stim_row_type r;
      r       = reg_row(CSR_PATTERN, 64'd0);
      r.kind  = ROW_BYTE;
      r.data  = d;
      r.last  = l;
      return r;
   endfunction

   function automatic stim_row_type known_row(input logic [7:0] d, input logic l,
                                              input logic [7:0] ob, input logic ol,
                                              input logic [31:0] mc, input logic f,
                                              input logic [31:0] fo);
      stim_row_type r;
      r = byte_row(d, l);
      r.typed             = 1'b1;
      r.want.out_byte     = ob;
      r.want.out_last     = ol;
      r.want.match_count  = mc;
      r.want.found        = f;
      r.want.first_offset = fo;
      return r;
   endfunction

   initial begin
      int unsigned random_target;
      int unsigned phase_end;
      int unsigned phase;
      logic [63:0] pat;
      logic [63:0] rep;
      logic [3:0]  len4;
      logic        en;

      cfg_now = '{pattern: 64'd0, length: 4'd4, replacement: 64'd0, replace_en: 1'b1};
      clear_buffer_state();

      // reset values: four zero bytes match the zero pattern
      directed_rows.push_back(byte_row(8'h00, 1'b0));
      directed_rows.push_back(byte_row(8'h00, 1'b0));
      directed_rows.push_back(byte_row(8'h00, 1'b0));
      directed_rows.push_back(byte_row(8'h00, 1'b0));
      directed_rows.push_back(byte_row(8'hFF, 1'b1));
      // zero length: no search, bytes go straight through
      directed_rows.push_back(reg_row(CSR_LENGTH, 64'd0));
      directed_rows.push_back(known_row(8'hFF, 1'b0, 8'hFF, 1'b0, 32'd0, 1'b0, 32'd0));
      directed_rows.push_back(known_row(8'h00, 1'b1, 8'h00, 1'b1, 32'd0, 1'b0, 32'd0));
      // single byte pattern, replaced
      directed_rows.push_back(reg_row(CSR_PATTERN, 64'hA5));
      directed_rows.push_back(reg_row(CSR_LENGTH, 64'd1));
      directed_rows.push_back(reg_row(CSR_REPLACEMENT, 64'h3C));
      directed_rows.push_back(known_row(8'hA5, 1'b0, 8'h3C, 1'b0, 32'd1, 1'b1, 32'd0));
      directed_rows.push_back(known_row(8'h11, 1'b0, 8'h11, 1'b0, 32'd1, 1'b1, 32'd0));
      directed_rows.push_back(known_row(8'hA5, 1'b1, 8'h3C, 1'b1, 32'd2, 1'b1, 32'd0));
      // count only
      directed_rows.push_back(reg_row(CSR_REPL_EN, 64'd0));
      directed_rows.push_back(known_row(8'hA5, 1'b1, 8'hA5, 1'b1, 32'd1, 1'b1, 32'd0));
      // full eight byte pattern at offset 1
      directed_rows.push_back(reg_row(CSR_PATTERN, 64'hFFEE_DDCC_BBAA_9988));
      directed_rows.push_back(reg_row(CSR_LENGTH, 64'd8));
      directed_rows.push_back(reg_row(CSR_REPLACEMENT, 64'h0011_2233_4455_6677));
      directed_rows.push_back(reg_row(CSR_REPL_EN, 64'd1));
      directed_rows.push_back(byte_row(8'h01, 1'b0));
      for (int i = 0; i < 8; i++) begin
         directed_rows.push_back(byte_row(8'h88 + 8'(i * 8'h11), 1'b0));
      end
      directed_rows.push_back(byte_row(8'h02, 1'b1));
      // oversize length clamps to eight; a short buffer leaves unchanged
      directed_rows.push_back(reg_row(CSR_LENGTH, 64'd15));
      directed_rows.push_back(byte_row(8'h88, 1'b0));
      directed_rows.push_back(byte_row(8'h99, 1'b1));
      // length lowered with bytes still held in the window
      directed_rows.push_back(reg_row(CSR_LENGTH, 64'd4));
      directed_rows.push_back(byte_row(8'h10, 1'b0));
      directed_rows.push_back(byte_row(8'h20, 1'b0));
      directed_rows.push_back(byte_row(8'h30, 1'b0));
      directed_rows.push_back(reg_row(CSR_LENGTH, 64'd2));
      directed_rows.push_back(byte_row(8'h40, 1'b1));

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) begin
         if (directed_rows[k].kind == ROW_WRITE) begin
            write_csr(directed_rows[k].index, directed_rows[k].value);
         end else begin
            send_byte(directed_rows[k].data, directed_rows[k].last,
                      directed_rows[k].typed, directed_rows[k].want);
         end
      end

      random_target = items_sent + RANDOM_WORDS;
      phase = 0;
      while (items_sent < random_target) begin
         narrow_alphabet = 1'b0;
         if (phase == 0) begin
            pat = '1;
            rep = '0;
            len4 = 4'd8;
            en = 1'b1;
         end else if (phase == 1) begin
            pat = '0;
            rep = '1;
            len4 = 4'd1;
            en = 1'b1;
         end else begin
            narrow_alphabet = ($urandom_range(0, 2) == 0);
            pat = {$urandom, $urandom};
            if (narrow_alphabet) begin
               for (int i = 0; i < 8; i++) begin
                  pat[8*i +: 8] = 8'h41 + 8'($urandom_range(0, 1));
               end
            end
            rep = {$urandom, $urandom};
            case ($urandom_range(0, 9))
               0:       len4 = 4'd0;
               1:       len4 = 4'($urandom_range(9, 15));
               default: len4 = 4'($urandom_range(1, 8));
            endcase
            en = 1'($urandom_range(0, 1));
         end
         write_csr(CSR_PATTERN, pat);
         write_csr(CSR_LENGTH, {60'd0, len4});
         write_csr(CSR_REPLACEMENT, rep);
         write_csr(CSR_REPL_EN, {63'd0, en});
         // one phase runs gap-free into a long result-side hold-off
         pressure_phase = (phase == 1);
         if (pressure_phase) begin
            hold_request = 1'b1;
         end
         phase_end = items_sent + (pressure_phase ? 40 : 20);
         while (items_sent < phase_end) begin
            send_buffer();
         end
         pressure_phase = 1'b0;
         steady_send = 1'b0;
         phase++;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d input words (%0d random buffers), %0d result words, %0d matches.",
               words_in, buffers_sent, words_out, hit_total);
      $display("%0d register writes over %0d random settings, %0d long result hold-off(s).",
               settings_written, phase, holds_done);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
